### src/aarm_pkg.sv
package aarm_pkg;

  localparam int IN_W             = 16;
  localparam int OUT_W            = 16;
  localparam int IN_FRAC_DEF      = 12;
  localparam int OUT_FRAC_DEF     = 14;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int WF    = 30;
  localparam int CW    = 36;
  localparam int NW    = 33;
  localparam int TH_W  = 31;
  localparam int SQ_W  = 64;
  localparam int DIV_Q = 32;
  localparam int TP_W  = 33;

  localparam logic [TP_W-1:0]      TWO_PI_Q  = 33'd6746518852;
  localparam logic signed [CW-1:0] PI_Q      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q    = 36'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q     = 36'sd1073741824;

  typedef logic signed [IN_W-1:0]  rot_t;
  typedef logic signed [OUT_W-1:0] elem_t;
  typedef logic signed [CW-1:0]    cord_t;
  typedef logic signed [NW-1:0]    axis_t;

  function automatic cord_t atan_q(input int k);
    cord_t v;
    case (k)
      0:  v = 36'sd843314857;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043837;
      3:  v = 36'sd133525159;
      4:  v = 36'sd67021687;
      5:  v = 36'sd33543516;
      6:  v = 36'sd16775851;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194283;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      12: v = 36'sd262143;
      13: v = 36'sd131071;
      14: v = 36'sd65535;
      15: v = 36'sd32767;
      16: v = 36'sd16383;
      17: v = 36'sd8191;
      18: v = 36'sd4095;
      19: v = 36'sd2047;
      20: v = 36'sd1023;
      21: v = 36'sd511;
      22: v = 36'sd255;
      23: v = 36'sd127;
      24: v = 36'sd63;
      25: v = 36'sd31;
      26: v = 36'sd15;
      27: v = 36'sd7;
      28: v = 36'sd3;
      29: v = 36'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/aarm_sqrt_cell.sv
module aarm_sqrt_cell import aarm_pkg::*; #(
  parameter int SIDE_W = 1,
  parameter int STEP   = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [SQ_W-1:0]   a_i,
  input  logic [SQ_W-1:0]   r_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [SQ_W-1:0]   a_o,
  output logic [SQ_W-1:0]   r_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [SQ_W-1:0] BIT = SQ_W'(64'd1 << (62 - 2 * STEP));

  logic              vld_r;
  logic [SQ_W-1:0]   a_r, a_nxt;
  logic [SQ_W-1:0]   r_r, r_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [SQ_W-1:0]   trial;

  always_comb begin
    trial = r_i + BIT;
    if (a_i >= trial) begin
      a_nxt = a_i - trial;
      r_nxt = (r_i >> 1) + BIT;
    end else begin
      a_nxt = a_i;
      r_nxt = r_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      r_r    <= r_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign a_o    = a_r;
  assign r_o    = r_r;
  assign side_o = side_r;

endmodule

### src/aarm_div_cell.sv
module aarm_div_cell import aarm_pkg::*; #(
  parameter int SIDE_W = 1,
  parameter int LANES  = 1,
  parameter int REM_W  = 64,
  parameter int D_W    = 31,
  parameter int Q_W    = 32,
  parameter int SHIFT  = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [LANES-1:0][REM_W-1:0] rem_i,
  input  logic [LANES-1:0][Q_W-1:0]   q_i,
  input  logic [D_W-1:0]              d_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [LANES-1:0][REM_W-1:0] rem_o,
  output logic [LANES-1:0][Q_W-1:0]   q_o,
  output logic [D_W-1:0]              d_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int CMP_W = REM_W + D_W + SHIFT;

  logic                        vld_r;
  logic [LANES-1:0][REM_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][Q_W-1:0]   q_r, q_nxt;
  logic [D_W-1:0]              d_r;
  logic [SIDE_W-1:0]           side_r;
  logic [CMP_W-1:0]            dsh;
  logic [CMP_W-1:0]            rem_ext;
  logic                        ge;

  always_comb begin
    dsh = CMP_W'(d_i) << SHIFT;
    for (int l = 0; l < LANES; l++) begin
      rem_ext = CMP_W'(rem_i[l]);
      ge      = rem_ext >= dsh;
      if (ge) begin
        rem_nxt[l] = REM_W'(rem_ext - dsh);
      end else begin
        rem_nxt[l] = rem_i[l];
      end
      q_nxt[l] = Q_W'({q_i[l], ge});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule

### src/aarm_cordic_cell.sv
module aarm_cordic_cell import aarm_pkg::*; #(
  parameter int SIDE_W = 1,
  parameter int STEP   = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  cord_t             x_i,
  input  cord_t             y_i,
  input  cord_t             z_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output cord_t             x_o,
  output cord_t             y_o,
  output cord_t             z_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam cord_t ATAN = atan_q(STEP);

  logic              vld_r;
  cord_t             x_r, x_nxt;
  cord_t             y_r, y_nxt;
  cord_t             z_r, z_nxt;
  logic [SIDE_W-1:0] side_r;
  cord_t             xs, ys;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!z_i[CW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

### src/aarm_mix.sv
module aarm_mix import aarm_pkg::*; #(
  parameter int OUT_FRAC = OUT_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  logic                  zero_i,
  input  logic                  neg_i,
  input  cord_t                 x_i,
  input  cord_t                 y_i,
  input  axis_t                 n0_i,
  input  axis_t                 n1_i,
  input  axis_t                 n2_i,
  output logic                  vld_o,
  output logic [8:0][OUT_W-1:0] m_o
);

  localparam int NNW = 34;
  localparam int OCW = 34;
  localparam int PW  = 38;
  localparam int EW  = 40;
  localparam int SH  = WF - OUT_FRAC;
  localparam longint HALF = (longint'(1) << SH) >> 1;
  localparam logic signed [EW-1:0] RND = EW'(HALF);
  localparam logic signed [EW-1:0] LIM = EW'(longint'(1) << OUT_FRAC);

  axis_t                    n [3];
  logic signed [2*NW-1:0]   pnn;
  logic signed [NNW-1:0]    nn_nxt [3][3];
  cord_t                    cs_nxt, sn_nxt;

  logic                     v1_r, z1_r;
  cord_t                    cs1_r, sn1_r;
  logic signed [NNW-1:0]    nn1_r [3][3];
  axis_t                    n1_r [3];

  logic signed [OCW-1:0]    oc;
  axis_t                    sk;
  logic signed [OCW+NNW-1:0] pp;
  logic signed [CW+NW-1:0]  pq;
  logic signed [PW-1:0]     p_nxt [3][3];
  logic signed [PW-1:0]     q_nxt [3][3];

  logic                     v2_r, z2_r;
  cord_t                    cs2_r;
  logic signed [PW-1:0]     p2_r [3][3];
  logic signed [PW-1:0]     q2_r [3][3];

  logic signed [EW-1:0]     e, rr;
  logic [8:0][OUT_W-1:0]    m_nxt;
  logic                     v3_r;
  logic [8:0][OUT_W-1:0]    m3_r;

  always_comb begin
    n[0] = n0_i;
    n[1] = n1_i;
    n[2] = n2_i;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pnn          = n[i] * n[j];
        nn_nxt[i][j] = pnn[WF +: NNW];
      end
    end
    cs_nxt = neg_i ? -x_i : x_i;
    sn_nxt = neg_i ? -y_i : y_i;
  end

  always_comb begin
    oc = OCW'(ONE_Q - cs1_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp          = oc * nn1_r[i][j];
        p_nxt[i][j] = pp[WF +: PW];
        case (i * 3 + j)
          1:       sk = -n1_r[2];
          2:       sk = n1_r[1];
          3:       sk = n1_r[2];
          5:       sk = -n1_r[0];
          6:       sk = -n1_r[1];
          7:       sk = n1_r[0];
          default: sk = '0;
        endcase
        pq          = sn1_r * sk;
        q_nxt[i][j] = pq[WF +: PW];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e = EW'(p2_r[i][j]) + EW'(q2_r[i][j]);
        if (i == j) begin
          e = e + EW'(cs2_r);
        end
        rr = (e + RND) >>> SH;
        if (rr > LIM) begin
          rr = LIM;
        end
        if (rr < -LIM) begin
          rr = -LIM;
        end
        if (z2_r) begin
          rr = (i == j) ? LIM : '0;
        end
        m_nxt[i * 3 + j] = rr[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r  <= zero_i;
      cs1_r <= cs_nxt;
      sn1_r <= sn_nxt;
      nn1_r <= nn_nxt;
      n1_r  <= n;
      z2_r  <= z1_r;
      cs2_r <= cs1_r;
      p2_r  <= p_nxt;
      q2_r  <= q_nxt;
      m3_r  <= m_nxt;
    end
  end

  assign vld_o = v3_r;
  assign m_o   = m3_r;

endmodule

### src/axis_angle_to_rotation_matrix.sv
// Rotation vector (Q3.12 radians, axis times angle) to 3x3 rotation matrix
// (Q1.14, saturated to +-1) by Rodrigues' formula. Fully pipelined: one
// transfer per cycle in and out unless a held output stalls the pipe. The
// path runs through an input sum-of-squares register, a 32-cell square-root
// chain, a 32-cell divider chain for the unit axis, a short modulo-2pi chain,
// a fold register, one CORDIC cell per step, a three-stage multiply-and-round
// tail and the output register. A zero vector gives the identity. Input is taken
// while a result waits as long as the last pipeline stage is empty.
module axis_angle_to_rotation_matrix import aarm_pkg::*; #(
  parameter int IN_FRAC_BITS = IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  rot_t  in_rot_x,
  input  rot_t  in_rot_y,
  input  rot_t  in_rot_z,
  output logic  out_valid,
  input  logic  out_ready,
  output elem_t out_m00,
  output elem_t out_m01,
  output elem_t out_m02,
  output elem_t out_m10,
  output elem_t out_m11,
  output elem_t out_m12,
  output elem_t out_m20,
  output elem_t out_m21,
  output elem_t out_m22
);

  localparam int FR        = IN_FRAC_BITS + 14;
  localparam int ANG_RAW   = (FR <= WF) ? (30 + WF - FR) : 30;
  localparam int ANG_W     = (ANG_RAW < 34) ? 34 : ANG_RAW;
  localparam int MOD_STEPS = ANG_W - 32;
  localparam int NSTEPS    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int SQ_SIDE   = 1 + 3 * IN_W;
  localparam int DV_SIDE   = 4 + ANG_W;
  localparam int MD_SIDE   = 1 + 3 * NW;
  localparam int CD_SIDE   = 2 + 3 * NW;

  logic en;

  // input stage: sum of squares
  logic [IN_W*2+1:0] ssum;
  logic              v0_r;
  logic [31:0]       s0_r;
  logic              z0_r;
  rot_t              vx0_r, vy0_r, vz0_r;

  always_comb begin
    ssum = 34'($signed(in_rot_x) * $signed(in_rot_x))
         + 34'($signed(in_rot_y) * $signed(in_rot_y))
         + 34'($signed(in_rot_z) * $signed(in_rot_z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r  <= ssum[31:0];
      z0_r  <= (ssum == '0);
      vx0_r <= in_rot_x;
      vy0_r <= in_rot_y;
      vz0_r <= in_rot_z;
    end
  end

  // square-root chain
  logic                sq_v [0:32];
  logic [SQ_W-1:0]     sq_a [0:32];
  logic [SQ_W-1:0]     sq_r [0:32];
  logic [SQ_SIDE-1:0]  sq_s [0:32];

  assign sq_v[0] = v0_r;
  assign sq_a[0] = {4'b0, s0_r, 28'b0};
  assign sq_r[0] = '0;
  assign sq_s[0] = {z0_r, vx0_r, vy0_r, vz0_r};

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    aarm_sqrt_cell #(.SIDE_W(SQ_SIDE), .STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(sq_v[k]), .a_i(sq_a[k]), .r_i(sq_r[k]), .side_i(sq_s[k]),
      .vld_o(sq_v[k+1]), .a_o(sq_a[k+1]), .r_o(sq_r[k+1]), .side_o(sq_s[k+1])
    );
  end

  // axis division chain
  logic [TH_W-1:0]  th;
  logic [ANG_W-1:0] ang;
  rot_t             vv [3];
  logic [IN_W-1:0]  mag [3];

  assign th = sq_r[32][TH_W-1:0];

  if (FR <= WF) begin : g_ang_l
    assign ang = ANG_W'(th) << (WF - FR);
  end else begin : g_ang_r
    assign ang = ANG_W'(th >> (FR - WF));
  end

  always_comb begin
    vv[0] = sq_s[32][3*IN_W-1:2*IN_W];
    vv[1] = sq_s[32][2*IN_W-1:IN_W];
    vv[2] = sq_s[32][IN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      mag[i] = vv[i][IN_W-1] ? IN_W'(-vv[i]) : IN_W'(vv[i]);
    end
  end

  logic                           dv_v [0:32];
  logic [2:0][SQ_W-1:0]           dv_rem [0:32];
  logic [2:0][DIV_Q-1:0]          dv_q [0:32];
  logic [TH_W-1:0]                dv_d [0:32];
  logic [DV_SIDE-1:0]             dv_s [0:32];

  assign dv_v[0]   = sq_v[32];
  assign dv_rem[0] = {{4'b0, mag[0], 44'b0}, {4'b0, mag[1], 44'b0}, {4'b0, mag[2], 44'b0}};
  assign dv_q[0]   = '0;
  assign dv_d[0]   = th;
  assign dv_s[0]   = {sq_s[32][SQ_SIDE-1], vv[0][IN_W-1], vv[1][IN_W-1], vv[2][IN_W-1], ang};

  for (genvar k = 0; k < 32; k++) begin : g_div
    aarm_div_cell #(
      .SIDE_W(DV_SIDE), .LANES(3), .REM_W(SQ_W), .D_W(TH_W), .Q_W(DIV_Q), .SHIFT(31 - k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(dv_v[k]), .rem_i(dv_rem[k]), .q_i(dv_q[k]), .d_i(dv_d[k]), .side_i(dv_s[k]),
      .vld_o(dv_v[k+1]), .rem_o(dv_rem[k+1]), .q_o(dv_q[k+1]), .d_o(dv_d[k+1]),
      .side_o(dv_s[k+1])
    );
  end

  // signed axis
  axis_t nax [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nax[i] = dv_s[32][ANG_W + 2 - i] ? -$signed({1'b0, dv_q[32][2 - i]})
                                        : $signed({1'b0, dv_q[32][2 - i]});
    end
  end

  // angle modulo 2pi chain
  logic                    md_v [0:MOD_STEPS];
  logic [0:0][ANG_W-1:0]   md_rem [0:MOD_STEPS];
  logic [0:0][1:0]         md_q [0:MOD_STEPS];
  logic [TP_W-1:0]         md_d [0:MOD_STEPS];
  logic [MD_SIDE-1:0]      md_s [0:MOD_STEPS];

  assign md_v[0]   = dv_v[32];
  assign md_rem[0] = dv_s[32][ANG_W-1:0];
  assign md_q[0]   = '0;
  assign md_d[0]   = TWO_PI_Q;
  assign md_s[0]   = {dv_s[32][DV_SIDE-1], nax[0], nax[1], nax[2]};

  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    aarm_div_cell #(
      .SIDE_W(MD_SIDE), .LANES(1), .REM_W(ANG_W), .D_W(TP_W), .Q_W(2),
      .SHIFT(MOD_STEPS - 1 - k)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(md_v[k]), .rem_i(md_rem[k]), .q_i(md_q[k]), .d_i(md_d[k]), .side_i(md_s[k]),
      .vld_o(md_v[k+1]), .rem_o(md_rem[k+1]), .q_o(md_q[k+1]), .d_o(md_d[k+1]),
      .side_o(md_s[k+1])
    );
  end

  // fold into [-pi/2, pi/2]
  cord_t              zf_nxt;
  logic               nf_nxt;
  logic               vf_r;
  cord_t              zf_r;
  logic               nf_r;
  logic [MD_SIDE-1:0] sf_r;

  always_comb begin
    zf_nxt = $signed({{(CW-TP_W){1'b0}}, md_rem[MOD_STEPS][0][TP_W-1:0]});
    nf_nxt = 1'b0;
    if (zf_nxt > PI_Q) begin
      zf_nxt = zf_nxt - $signed({{(CW-TP_W){1'b0}}, TWO_PI_Q});
    end
    if (zf_nxt > HALF_PI_Q) begin
      zf_nxt = zf_nxt - PI_Q;
      nf_nxt = 1'b1;
    end else if (zf_nxt < -HALF_PI_Q) begin
      zf_nxt = zf_nxt + PI_Q;
      nf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= md_v[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r <= zf_nxt;
      nf_r <= nf_nxt;
      sf_r <= md_s[MOD_STEPS];
    end
  end

  // CORDIC chain
  logic               cd_v [0:NSTEPS];
  cord_t              cd_x [0:NSTEPS];
  cord_t              cd_y [0:NSTEPS];
  cord_t              cd_z [0:NSTEPS];
  logic [CD_SIDE-1:0] cd_s [0:NSTEPS];

  assign cd_v[0] = vf_r;
  assign cd_x[0] = GAIN_Q;
  assign cd_y[0] = '0;
  assign cd_z[0] = zf_r;
  assign cd_s[0] = {nf_r, sf_r};

  for (genvar k = 0; k < NSTEPS; k++) begin : g_cordic
    aarm_cordic_cell #(.SIDE_W(CD_SIDE), .STEP(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_i(cd_v[k]), .x_i(cd_x[k]), .y_i(cd_y[k]), .z_i(cd_z[k]), .side_i(cd_s[k]),
      .vld_o(cd_v[k+1]), .x_o(cd_x[k+1]), .y_o(cd_y[k+1]), .z_o(cd_z[k+1]),
      .side_o(cd_s[k+1])
    );
  end

  // matrix assembly
  logic                  mx_v;
  logic [8:0][OUT_W-1:0] mx_m;

  aarm_mix #(.OUT_FRAC(OUT_FRAC_BITS)) u_mix (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(cd_v[NSTEPS]),
    .zero_i(cd_s[NSTEPS][CD_SIDE-2]),
    .neg_i(cd_s[NSTEPS][CD_SIDE-1]),
    .x_i(cd_x[NSTEPS]),
    .y_i(cd_y[NSTEPS]),
    .n0_i(cd_s[NSTEPS][3*NW-1:2*NW]),
    .n1_i(cd_s[NSTEPS][2*NW-1:NW]),
    .n2_i(cd_s[NSTEPS][NW-1:0]),
    .vld_o(mx_v),
    .m_o(mx_m)
  );

  // output register; advance the pipe unless a held result would be overwritten
  logic                  out_valid_r;
  logic [8:0][OUT_W-1:0] out_m_r;

  assign en       = !out_valid_r || out_ready || !mx_v;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= mx_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_m_r <= mx_m;
    end
  end

  assign out_valid = out_valid_r;
  assign out_m00   = out_m_r[0];
  assign out_m01   = out_m_r[1];
  assign out_m02   = out_m_r[2];
  assign out_m10   = out_m_r[3];
  assign out_m11   = out_m_r[4];
  assign out_m12   = out_m_r[5];
  assign out_m20   = out_m_r[6];
  assign out_m21   = out_m_r[7];
  assign out_m22   = out_m_r[8];

endmodule

### tb/axis_angle_to_rotation_matrix_chk.sv
module axis_angle_to_rotation_matrix_chk import aarm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  rot_t in_rot_x,
  input  rot_t in_rot_y,
  input  rot_t in_rot_z,
  input  logic out_valid,
  input  logic out_ready,
  input  elem_t out_m00,
  input  elem_t out_m01,
  input  elem_t out_m02,
  input  elem_t out_m10,
  input  elem_t out_m11,
  input  elem_t out_m12,
  input  elem_t out_m20,
  input  elem_t out_m21,
  input  elem_t out_m22,
  output int   mismatches,
  output int   matrices_due,
  output int   matrices_seen
);

  localparam int IN_FB = 12;
  localparam int OUT_FB = 14;
  localparam int STEPS = 16;

  typedef struct packed {
    elem_t [8:0] m;
  } matrix_t;

  matrix_t expected_matrices[$];

  function automatic longint unsigned int_sqrt(input longint unsigned a);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic elem_t round_sat(input longint q);
    longint r;
    longint lim;
    lim = longint'(1) << OUT_FB;
    r = (q + (longint'(1) << (WF - OUT_FB - 1))) >>> (WF - OUT_FB);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return elem_t'(r[15:0]);
  endfunction

  function automatic matrix_t rodrigues(input rot_t rx, input rot_t ry, input rot_t rz);
    matrix_t res;
    longint v[3];
    longint n[3];
    longint sk[3][3];
    longint unsigned s;
    longint unsigned th;
    longint unsigned mag;
    longint x, y, z, nx, c, sn, oc, nn, e;
    bit flip;
    v[0] = rx;
    v[1] = ry;
    v[2] = rz;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    if (s == 0) begin
      for (int i = 0; i < 9; i++)
        res.m[i] = (i % 4 == 0) ? round_sat(longint'(ONE_Q)) : elem_t'(0);
      return res;
    end
    th = int_sqrt(s << 28);
    for (int i = 0; i < 3; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      nn = longint'((mag << 44) / th);
      n[i] = (v[i] < 0) ? -nn : nn;
    end
    z = longint'(th << (WF - IN_FB - 14));
    z = z % longint'(TWO_PI_Q);
    if (z > longint'(PI_Q)) z -= longint'(TWO_PI_Q);
    flip = 0;
    if (z > longint'(HALF_PI_Q)) begin
      z -= longint'(PI_Q);
      flip = 1;
    end else if (z < -longint'(HALF_PI_Q)) begin
      z += longint'(PI_Q);
      flip = 1;
    end
    x = longint'(GAIN_Q);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_q(i));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_q(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    sn = flip ? -y : y;
    oc = longint'(ONE_Q) - c;
    sk[0][0] = 0;     sk[0][1] = -n[2]; sk[0][2] = n[1];
    sk[1][0] = n[2];  sk[1][1] = 0;     sk[1][2] = -n[0];
    sk[2][0] = -n[1]; sk[2][1] = n[0];  sk[2][2] = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nn = (n[i] * n[j]) >>> WF;
        e = ((oc * nn) >>> WF) + ((sn * sk[i][j]) >>> WF);
        if (i == j) e += c;
        res.m[i * 3 + j] = round_sat(e);
      end
    end
    return res;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    matrices_seen = 0;
    matrices_due = 0;
  end

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_matrices.push_back(rodrigues(in_rot_x, in_rot_y, in_rot_z));
      if (out_valid && out_ready) begin
        got.m = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
                 out_m02, out_m01, out_m00};
        matrices_seen++;
        if (expected_matrices.size() == 0) begin
          report("matrix with no pending rotation vector");
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++)
            if (got.m[k] !== want.m[k])
              report($sformatf("m%0d%0d got %0d want %0d", k / 3, k % 3,
                               got.m[k], want.m[k]));
        end
      end
    end
    matrices_due = expected_matrices.size();
  end

endmodule

### tb/axis_angle_to_rotation_matrix_tb.sv
module axis_angle_to_rotation_matrix_tb import aarm_pkg::*;;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  rot_t in_rot_x, in_rot_y, in_rot_z;
  logic out_valid;
  logic out_ready;
  elem_t out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22;
  int mismatches;
  int matrices_due;
  int matrices_seen;
  bit throttle;
  int vectors_sent;

  axis_angle_to_rotation_matrix dut (.*);

  axis_angle_to_rotation_matrix_chk chk (.*);

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    in_rot_x = '0;
    in_rot_y = '0;
    in_rot_z = '0;
    throttle = 1;
  end

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(negedge clk)
    out_ready <= rst_n && (!throttle || $urandom_range(99) >= 32);

  task automatic send_vector(input rot_t x, input rot_t y, input rot_t z);
    while (throttle && $urandom_range(99) < 32) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_rot_x <= x;
    in_rot_y <= y;
    in_rot_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    vectors_sent++;
    @(negedge clk);
  endtask

  function automatic rot_t pick_component(input int mode);
    case (mode)
      0: return rot_t'($urandom_range(65535));
      1: return rot_t'($signed($urandom_range(8191)) - 4096);
      2: return rot_t'($signed($urandom_range(64)) - 32);
      default: return '0;
    endcase
  endfunction

  initial begin
    int mode;
    vectors_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_vector(0, 0, 0);
    send_vector(-32768, 0, 0);
    send_vector(0, 32767, 0);
    send_vector(0, 0, -32768);
    send_vector(32767, 32767, 32767);
    send_vector(-32768, -32768, -32768);
    send_vector(1, 0, 0);
    send_vector(0, -1, 0);
    send_vector(0, 0, 1);
    send_vector(12868, 0, 0);
    send_vector(0, -12868, 0);
    send_vector(0, 0, 6434);
    send_vector(25736, 0, 0);
    send_vector(7430, 7430, 7430);
    send_vector(-3000, 4000, 0);
    send_vector(1, 1, 1);
    send_vector(32767, -32768, 1);
    send_vector(0, 0, 0);
    for (int i = 0; i < 1800; i++) begin
      throttle = !(i >= 600 && i < 900);
      if (i == 1200) begin
        in_valid <= 0;
        @(negedge clk);
        while (matrices_due != 0) @(negedge clk);
      end
      mode = $urandom_range(9);
      if (mode < 4)
        send_vector(pick_component(0), pick_component(0), pick_component(0));
      else if (mode < 7)
        send_vector(pick_component(1), pick_component(1), pick_component(1));
      else if (mode < 8)
        send_vector(pick_component(2), pick_component(2), pick_component(2));
      else
        send_vector(pick_component(0), pick_component(3), pick_component(0));
    end
    in_valid <= 0;
    throttle = 1;
    while (matrices_due != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("sent %0d rotation vectors (zero, full-scale and random axes/angles),",
             vectors_sent);
    $display("checked %0d matrices with random stalls on both sides", matrices_seen);
    if (mismatches == 0)
      $display("axis_angle_to_rotation_matrix regression: pass");
    else
      $display("axis_angle_to_rotation_matrix regression: fail");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("axis_angle_to_rotation_matrix regression: fail");
    $finish;
  end

endmodule

### files.f
src/aarm_pkg.sv
src/aarm_sqrt_cell.sv
src/aarm_div_cell.sv
src/aarm_cordic_cell.sv
src/aarm_mix.sv
src/axis_angle_to_rotation_matrix.sv
tb/axis_angle_to_rotation_matrix_chk.sv
tb/axis_angle_to_rotation_matrix_tb.sv
